FILE: sv/anb_pkg.sv
// ----------------------------------------------------------------------------
// anb_pkg
// Shared types, codes and decode functions for the Annex B NAL splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package anb_pkg;

  // Input transaction: one stream byte and its buffer-end mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_t;

  // Output transaction: one record per finished NAL
  typedef struct packed {
    logic [5:0]  nal_type;
    logic [2:0]  nal_class;
    logic [23:0] nal_length;
    logic [23:0] nal_end_offset;
    logic [7:0]  nal_index;
    logic        frame_end;
    logic [23:0] frame_length;
    logic [23:0] lead_bytes;
    logic [31:0] time_stamp;
  } out_t;

  // Live register values handed to the scanner
  typedef struct packed {
    logic        codec_mode;
    logic [15:0] timestamp_step;
  } cfg_t;

  // Codec selection
  localparam logic MODE_H264 = 1'b0;
  localparam logic MODE_H265 = 1'b1;

  // Register indexes
  localparam logic REG_CODEC_MODE = 1'b0;
  localparam logic REG_TS_STEP    = 1'b1;

  localparam logic [15:0] TS_STEP_RESET = 16'd3600;

  // NAL class codes
  localparam logic [2:0] CLS_OTHER = 3'd0;
  localparam logic [2:0] CLS_P     = 3'd1;
  localparam logic [2:0] CLS_I     = 3'd2;
  localparam logic [2:0] CLS_SPS   = 3'd3;
  localparam logic [2:0] CLS_PPS   = 3'd4;
  localparam logic [2:0] CLS_VPS   = 3'd5;

  // H.264 NAL types of interest
  localparam logic [5:0] AVC_SLICE = 6'd1;
  localparam logic [5:0] AVC_IDR   = 6'd5;
  localparam logic [5:0] AVC_SPS   = 6'd7;
  localparam logic [5:0] AVC_PPS   = 6'd8;

  // H.265 NAL types of interest
  localparam logic [5:0] HEVC_VPS = 6'd32;
  localparam logic [5:0] HEVC_SPS = 6'd33;
  localparam logic [5:0] HEVC_PPS = 6'd34;

  localparam logic [7:0] AVC_TYPE_MASK  = 8'h1f;
  localparam logic [7:0] HEVC_TYPE_MASK = 8'h7e;

  // Extract the NAL type from a header byte
  function automatic logic [5:0] decode_type(input logic [7:0] hdr, input logic mode);
    logic [7:0] masked;
    masked = (mode == MODE_H264) ? (hdr & AVC_TYPE_MASK) : ((hdr & HEVC_TYPE_MASK) >> 1);
    return masked[5:0];
  endfunction

  // Map a NAL type to its class
  function automatic logic [2:0] classify(input logic [5:0] t, input logic mode);
    logic [2:0] cls;
    cls = CLS_OTHER;
    if (mode == MODE_H264) begin
      case (t)
        AVC_SLICE: cls = CLS_P;
        AVC_IDR:   cls = CLS_I;
        AVC_SPS:   cls = CLS_SPS;
        AVC_PPS:   cls = CLS_PPS;
        default:   cls = CLS_OTHER;
      endcase
    end else begin
      case (t) inside
        [6'd0:6'd9]:   cls = CLS_P;
        [6'd16:6'd21]: cls = CLS_I;
        HEVC_VPS:      cls = CLS_VPS;
        HEVC_SPS:      cls = CLS_SPS;
        HEVC_PPS:      cls = CLS_PPS;
        default:       cls = CLS_OTHER;
      endcase
    end
    return cls;
  endfunction

  // Clamp a 32-bit count to the 24-bit record fields
  function automatic logic [23:0] sat24(input logic [31:0] v);
    return (v > 32'h00ff_ffff) ? 24'hff_ffff : v[23:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/anb_scan.sv
// ----------------------------------------------------------------------------
// anb_scan
// Start-code scanner and NAL/frame bookkeeping; builds one record per NAL.
// ----------------------------------------------------------------------------
`default_nettype none

module anb_scan #(
  parameter int OFFSET_BITS = 24,
  parameter int MAX_NALS    = 255
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire anb_pkg::in_t  item,
  input  wire anb_pkg::cfg_t cfg,
  output logic               rec_valid,
  output anb_pkg::out_t      rec
);
  import anb_pkg::*;

  localparam int CW = $clog2(MAX_NALS + 1);
  localparam logic [OFFSET_BITS-1:0] POS_LIMIT = '1;
  localparam logic [CW-1:0] CNT_LIMIT = CW'(MAX_NALS);

  logic [1:0]             zero_run,         zero_run_next;
  logic [OFFSET_BITS-1:0] frame_position,   frame_position_next;
  logic                   nal_open,         nal_open_next;
  logic [OFFSET_BITS-1:0] nal_start_offset, nal_start_offset_next;
  logic                   nal_long_code,    nal_long_code_next;
  logic                   header_pending,   header_pending_next;
  logic [5:0]             held_nal_type,    held_nal_type_next;
  logic [CW-1:0]          nal_counter,      nal_counter_next;
  logic [OFFSET_BITS-1:0] skipped_bytes,    skipped_bytes_next;
  logic [31:0]            running_stamp,    running_stamp_next;

  logic                   start;
  logic                   is_long;
  logic [OFFSET_BITS-1:0] back;
  logic [OFFSET_BITS-1:0] pos;
  logic [OFFSET_BITS-1:0] idx;
  logic [OFFSET_BITS-1:0] len;
  logic [5:0]             cur_type;
  logic [2:0]             cls;
  logic                   closes;
  logic [31:0]            stamp_sum;
  logic [31:0]            cnt_ext;

  always_comb begin
    cur_type = header_pending ? decode_type(item.data_byte, cfg.codec_mode) : held_nal_type;
    start    = (item.data_byte == 8'd1) &&
               ((cfg.codec_mode == MODE_H264) ? (zero_run >= 2'd2) : (zero_run == 2'd3));
    is_long  = (zero_run == 2'd3);
    back     = is_long ? OFFSET_BITS'(3) : OFFSET_BITS'(2);

    // Start-code position, pinned once the frame counter has saturated
    if (frame_position == POS_LIMIT) begin
      idx = POS_LIMIT;
    end else if (frame_position >= back) begin
      idx = frame_position - back;
    end else begin
      idx = '0;
    end

    len = (idx >= nal_start_offset) ? (idx - nal_start_offset) : '0;
    cls = (len > (nal_long_code ? OFFSET_BITS'(4) : OFFSET_BITS'(3)))
          ? classify(cur_type, cfg.codec_mode) : CLS_OTHER;
    closes    = (cls == CLS_P) || (cls == CLS_I);
    stamp_sum = running_stamp + 32'(cfg.timestamp_step);
    cnt_ext   = 32'(nal_counter);

    rec_valid           = take && start && nal_open;
    rec.nal_type        = cur_type;
    rec.nal_class       = cls;
    rec.nal_length      = sat24(32'(len));
    rec.nal_end_offset  = sat24(32'(idx));
    rec.nal_index       = (cnt_ext > 32'd255) ? 8'hff : cnt_ext[7:0];
    rec.frame_end       = closes;
    rec.frame_length    = sat24(32'(idx));
    rec.lead_bytes      = sat24(32'(skipped_bytes));
    rec.time_stamp      = closes ? stamp_sum : running_stamp;

    zero_run_next         = zero_run;
    nal_open_next         = nal_open;
    nal_start_offset_next = nal_start_offset;
    nal_long_code_next    = nal_long_code;
    header_pending_next   = 1'b0;
    held_nal_type_next    = cur_type;
    nal_counter_next      = nal_counter;
    skipped_bytes_next    = skipped_bytes;
    running_stamp_next    = running_stamp;
    pos                   = frame_position;

    if (start) begin
      if (!nal_open) begin
        // First start code of a frame: rebase positions on it
        skipped_bytes_next    = idx;
        nal_start_offset_next = '0;
        nal_counter_next      = '0;
        pos                   = back;
      end else if (closes) begin
        running_stamp_next    = stamp_sum;
        skipped_bytes_next    = '0;
        nal_start_offset_next = '0;
        nal_counter_next      = '0;
        pos                   = back;
      end else begin
        nal_start_offset_next = idx;
        if (nal_counter < CNT_LIMIT) begin
          nal_counter_next = nal_counter + CW'(1);
        end
      end
      nal_open_next       = 1'b1;
      nal_long_code_next  = is_long;
      header_pending_next = 1'b1;
      zero_run_next       = 2'd0;
    end else if (item.data_byte == 8'd0) begin
      if (zero_run != 2'd3) begin
        zero_run_next = zero_run + 2'd1;
      end
    end else begin
      zero_run_next = 2'd0;
    end

    frame_position_next = (pos == POS_LIMIT) ? POS_LIMIT : pos + OFFSET_BITS'(1);

    // Drop the open NAL and frame counts at a buffer boundary
    if (item.buffer_end) begin
      zero_run_next         = 2'd0;
      frame_position_next   = '0;
      nal_open_next         = 1'b0;
      nal_start_offset_next = '0;
      nal_long_code_next    = 1'b0;
      header_pending_next   = 1'b0;
      held_nal_type_next    = '0;
      nal_counter_next      = '0;
      skipped_bytes_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run         <= '0;
      frame_position   <= '0;
      nal_open         <= 1'b0;
      nal_start_offset <= '0;
      nal_long_code    <= 1'b0;
      header_pending   <= 1'b0;
      held_nal_type    <= '0;
      nal_counter      <= '0;
      skipped_bytes    <= '0;
      running_stamp    <= '0;
    end else if (take) begin
      zero_run         <= zero_run_next;
      frame_position   <= frame_position_next;
      nal_open         <= nal_open_next;
      nal_start_offset <= nal_start_offset_next;
      nal_long_code    <= nal_long_code_next;
      header_pending   <= header_pending_next;
      held_nal_type    <= held_nal_type_next;
      nal_counter      <= nal_counter_next;
      skipped_bytes    <= skipped_bytes_next;
      running_stamp    <= running_stamp_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/anb_outbuf.sv
// ----------------------------------------------------------------------------
// anb_outbuf
// Output register with one skid entry for NAL records.
// ----------------------------------------------------------------------------
`default_nettype none

module anb_outbuf (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire anb_pkg::out_t push_data,
  output logic               full,
  output logic               out_valid,
  input  wire logic          out_stall,
  output anb_pkg::out_t      out_data
);
  import anb_pkg::*;

  logic skid_valid;
  out_t skid_data;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      // Output slot frees up: refill from skid first
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: sv/annexb_nal_frame_splitter_core.sv
// ----------------------------------------------------------------------------
// annexb_nal_frame_splitter_core
// Annex B byte-stream splitter: finds start codes, emits one record per NAL.
// ----------------------------------------------------------------------------
//
//   channel  | signals                              | direction
//   ---------+--------------------------------------+-----------
//   in       | in_valid, in_stall, in_data (in_t)   | byte in
//   out      | out_valid, out_stall, out_data (out_t)| record out
//   cfg      | psel, penable, pwrite, paddr, pwdata, | APB regs
//            | prdata, pready                       |
//
// One byte per clock while in_stall is low: each accepted byte is decoded in
// the cycle it is taken and its record, if any, is registered at the same edge,
// into the output register or, behind a stalled output, into the skid entry.
// in_stall rises only while the skid entry behind a stalled output register
// is occupied; a record waiting on out_stall does not hold off the input.
// rst (synchronous) clears all stream state, the timestamp and the registers.
// ----------------------------------------------------------------------------
`default_nettype none

module annexb_nal_frame_splitter_core #(
  parameter int OFFSET_BITS = 24,
  parameter int MAX_NALS    = 255
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire anb_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output anb_pkg::out_t      out_data,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import anb_pkg::*;

  cfg_t cfg;
  logic take;
  logic rec_valid;
  out_t rec;
  logic full;
  logic wr_en;
  logic reg_sel;

  // Registers sit at 4-byte strides; bit 2 picks the register
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.codec_mode     <= MODE_H264;
      cfg.timestamp_step <= TS_STEP_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_CODEC_MODE: cfg.codec_mode     <= pwdata[0];
        REG_TS_STEP:    cfg.timestamp_step <= pwdata[15:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CODEC_MODE: prdata = {31'd0, cfg.codec_mode};
      REG_TS_STEP:    prdata = {16'd0, cfg.timestamp_step};
      default:        prdata = '0;
    endcase
  end

  // Hold the input only when no room is left for a record
  assign in_stall = full;
  assign take     = in_valid && !full;

  anb_scan #(
    .OFFSET_BITS (OFFSET_BITS),
    .MAX_NALS    (MAX_NALS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (in_data),
    .cfg       (cfg),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  anb_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (rec_valid),
    .push_data (rec),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: tb/sv/annexb_nal_frame_splitter_core_tb.sv
// ----------------------------------------------------------------------------
// annexb_nal_frame_splitter_core_tb
// Self-checking bench for the Annex B NAL splitter: a directed byte table,
// then random NAL streams with junk bytes under both codec modes, random input
// gaps and output stalls, all scored against a cycle-free scanner model.
// ----------------------------------------------------------------------------

module annexb_nal_frame_splitter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import anb_pkg::*;

  localparam int unsigned POS_LIMIT    = 32'h00ff_ffff;
  localparam int unsigned NAL_CAP      = 255;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          PLAN_ROWS    = 28;

  // One row of the directed table; rec and has_rec count only when typed is set
  typedef struct {
    logic [7:0] data;
    bit         last;
    bit         typed;
    bit         has_rec;
    out_t       rec;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  annexb_nal_frame_splitter_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scanner model: register copies and stream state
  // --------------------------------------------------------------------------
  logic        mode_q;
  logic [15:0] step_q;
  logic [1:0]  zero_seen;
  int unsigned frame_pos;
  bit          nal_live;
  int unsigned nal_base;
  bit          nal_is_long;
  bit          hdr_due;
  logic [5:0]  hdr_type;
  int unsigned nals_in_frame;
  int unsigned lead_skip;
  logic [31:0] stamp;

  out_t records_due[$];  // records predicted but not yet seen at the output
  row_t typed_due[$];    // directed rows in flight, in send order
  int   errors = 0;
  int   sent = 0;
  bit   idle_gaps = 1'b1;
  int   cycles = 0;
  int   stall_left = 0;

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
    errors++;
  endtask

  task automatic check_record(string tag, out_t got, out_t want);
    if (got.nal_type != want.nal_type)
      report({tag, " nal_type"}, got.nal_type, want.nal_type);
    if (got.nal_class != want.nal_class)
      report({tag, " nal_class"}, got.nal_class, want.nal_class);
    if (got.nal_length != want.nal_length)
      report({tag, " nal_length"}, got.nal_length, want.nal_length);
    if (got.nal_end_offset != want.nal_end_offset)
      report({tag, " nal_end_offset"}, got.nal_end_offset, want.nal_end_offset);
    if (got.nal_index != want.nal_index)
      report({tag, " nal_index"}, got.nal_index, want.nal_index);
    if (got.frame_end != want.frame_end)
      report({tag, " frame_end"}, got.frame_end, want.frame_end);
    if (got.frame_length != want.frame_length)
      report({tag, " frame_length"}, got.frame_length, want.frame_length);
    if (got.lead_bytes != want.lead_bytes)
      report({tag, " lead_bytes"}, got.lead_bytes, want.lead_bytes);
    if (got.time_stamp != want.time_stamp)
      report({tag, " time_stamp"}, got.time_stamp, want.time_stamp);
  endtask

  function automatic logic [23:0] clamp24(int unsigned v);
    return (v > 32'h00ff_ffff) ? 24'hff_ffff : v[23:0];
  endfunction

  // Class of a NAL type under the given codec rules
  function automatic logic [2:0] nal_class_of(logic [5:0] t, logic m);
    if (m == MODE_H264) begin
      if (t == AVC_SLICE) return CLS_P;
      if (t == AVC_IDR)   return CLS_I;
      if (t == AVC_SPS)   return CLS_SPS;
      if (t == AVC_PPS)   return CLS_PPS;
      return CLS_OTHER;
    end
    if (t <= 6'd9)                 return CLS_P;
    if (t >= 6'd16 && t <= 6'd21) return CLS_I;
    if (t == HEVC_VPS)            return CLS_VPS;
    if (t == HEVC_SPS)            return CLS_SPS;
    if (t == HEVC_PPS)            return CLS_PPS;
    return CLS_OTHER;
  endfunction

  task automatic drop_stream();
    zero_seen     = '0;
    frame_pos     = 0;
    nal_live      = 1'b0;
    nal_base      = 0;
    nal_is_long   = 1'b0;
    hdr_due       = 1'b0;
    hdr_type      = '0;
    nals_in_frame = 0;
    lead_skip     = 0;
  endtask

  // Advance the model by one accepted byte; made is set when a NAL ends here
  task automatic scan_byte(input in_t it, output bit made, output out_t rec);
    int unsigned pos, back, idx, len, own;
    bit          long_code, closes;
    logic [2:0]  cls;
    made = 1'b0;
    rec  = '0;
    pos  = frame_pos;
    // The byte after a start code carries the type, decoded with today's mode
    if (hdr_due) begin
      hdr_type = (mode_q == MODE_H264) ? {1'b0, it.data_byte[4:0]} : it.data_byte[6:1];
      hdr_due  = 1'b0;
    end
    if (it.data_byte == 8'd1 && zero_seen >= ((mode_q == MODE_H264) ? 2'd2 : 2'd3)) begin
      long_code = (zero_seen == 2'd3);
      back      = long_code ? 3 : 2;
      if (pos >= POS_LIMIT) idx = POS_LIMIT;
      else                  idx = (pos >= back) ? pos - back : 0;
      if (!nal_live) begin
        // First start code of a frame: everything before it is lead-in
        lead_skip     = idx;
        nal_base      = 0;
        nals_in_frame = 0;
        pos           = back;
      end else begin
        len    = (idx >= nal_base) ? idx - nal_base : 0;
        own    = nal_is_long ? 4 : 3;
        cls    = (len > own) ? nal_class_of(hdr_type, mode_q) : CLS_OTHER;
        closes = (cls == CLS_P || cls == CLS_I);
        if (closes) stamp = stamp + step_q;
        rec.nal_type       = hdr_type;
        rec.nal_class      = cls;
        rec.nal_length     = clamp24(len);
        rec.nal_end_offset = clamp24(idx);
        rec.nal_index      = (nals_in_frame > 255) ? 8'd255 : nals_in_frame[7:0];
        rec.frame_end      = closes;
        rec.frame_length   = clamp24(idx);
        rec.lead_bytes     = clamp24(lead_skip);
        rec.time_stamp     = stamp;
        made = 1'b1;
        if (closes) begin
          lead_skip     = 0;
          nal_base      = 0;
          nals_in_frame = 0;
          pos           = back;
        end else begin
          nal_base = idx;
          if (nals_in_frame < NAL_CAP) nals_in_frame++;
        end
      end
      nal_live    = 1'b1;
      nal_is_long = long_code;
      hdr_due     = 1'b1;
      zero_seen   = '0;
    end else if (it.data_byte == 8'd0) begin
      if (zero_seen < 2'd3) zero_seen++;
    end else begin
      zero_seen = '0;
    end
    frame_pos = (pos >= POS_LIMIT) ? POS_LIMIT : pos + 1;
    if (it.buffer_end) drop_stream();
  endtask

  // --------------------------------------------------------------------------
  // Scoreboard: score output records first, then predict from the input side
  // --------------------------------------------------------------------------
  out_t mon_rec;
  out_t mon_want;
  bit   mon_made;
  row_t mon_row;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (records_due.size() == 0) begin
          report("record with nothing expected, nal_type", out_data.nal_type, 0);
        end else begin
          mon_want = records_due.pop_front();
          check_record("record", out_data, mon_want);
        end
      end
      if (in_valid && !in_stall) begin
        scan_byte(in_data, mon_made, mon_rec);
        if (mon_made) records_due.push_back(mon_rec);
        // Directed rows also hold the model to the hand-worked answer
        if (typed_due.size() != 0) begin
          mon_row = typed_due.pop_front();
          if (mon_row.typed) begin
            if (mon_made != mon_row.has_rec)
              report("table record present", mon_made, mon_row.has_rec);
            else if (mon_made)
              check_record("table", mon_rec, mon_row.rec);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Idle length: mostly short, now and then long
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  // Receiver: alternate stall bursts with free runs, some of them long
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left == 0) begin
      if (out_stall) begin
        out_stall  <= 1'b0;
        stall_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(1, 12);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= pick_len();
      end
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Present one byte, hold it until the transaction is taken
  task automatic send_byte(logic [7:0] d, bit last);
    int gap;
    gap = (idle_gaps && $urandom_range(0, 1) == 0) ? pick_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: d, buffer_end: last};
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Drop valid and wait until every record is home and the pipe is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (records_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write: setup then access; upper data bits are junk and must drop
  task automatic write_reg(logic reg_idx, logic [15:0] val);
    logic [31:0] word;
    word = $urandom;
    if (reg_idx == REG_CODEC_MODE) word[0] = val[0];
    else                           word[15:0] = val;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= word;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_CODEC_MODE) mode_q = word[0];
    else                           step_q = word[15:0];
  endtask

  // One NAL: zero run, 01, optional header, random payload
  task automatic make_nal();
    int         sel, zeros, plen, k;
    logic [5:0] t;
    logic [7:0] hdr, d;
    bit         cut;
    cut = ($urandom_range(0, 29) == 0);
    sel = $urandom_range(0, 9);
    if (sel <= 4)      zeros = (mode_q == MODE_H264) ? 2 : 3;
    else if (sel <= 7) zeros = 3;
    else if (sel == 8) zeros = $urandom_range(4, 6);  // over-long zero run
    else               zeros = 2;                     // short code, no start in H.265
    repeat (zeros) send_byte(8'h00, 1'b0);
    // No header: the NAL ends at once, with no payload
    if ($urandom_range(0, 15) == 0) begin
      send_byte(8'h01, cut);
      return;
    end
    send_byte(8'h01, 1'b0);
    sel = $urandom_range(0, 5);
    if (mode_q == MODE_H264) begin
      case (sel)
        0:       t = AVC_SLICE;
        1:       t = AVC_IDR;
        2:       t = AVC_SPS;
        3:       t = AVC_PPS;
        4:       t = 6'd6;
        default: t = 6'($urandom_range(0, 31));
      endcase
      hdr = {3'($urandom_range(0, 7)), t[4:0]};
    end else begin
      case (sel)
        0:       t = 6'($urandom_range(0, 9));
        1:       t = 6'($urandom_range(16, 21));
        2:       t = HEVC_VPS;
        3:       t = HEVC_SPS;
        4:       t = HEVC_PPS;
        default: t = 6'($urandom_range(0, 63));
      endcase
      hdr = {1'($urandom_range(0, 1)), t, 1'($urandom_range(0, 1))};
    end
    plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
    send_byte(hdr, cut && plen == 0);
    for (k = 0; k < plen; k++) begin
      d = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      send_byte(d, cut && k == plen - 1);
    end
  endtask

  // Junk bytes between NALs, zeros weighted up
  task automatic make_noise();
    int         n;
    logic [7:0] d;
    n = $urandom_range(1, 6);
    repeat (n) begin
      d = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
      send_byte(d, $urandom_range(0, 19) == 0);
    end
  endtask

  task automatic feed_random(int count);
    int first;
    first = sent;
    while (sent - first < count) begin
      if ($urandom_range(0, 9) == 0) make_noise();
      else                           make_nal();
    end
  endtask

  // Many short non-slice NALs in one frame to push the index into saturation
  task automatic feed_param_run();
    int k;
    for (k = 0; k < 260; k++) begin
      repeat ((mode_q == MODE_H264) ? 2 : 3) send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b0);
      if (k % 8 == 0) send_byte((mode_q == MODE_H264) ? 8'h06 : 8'h40, 1'b0);
    end
  endtask

  function automatic out_t rec_of(logic [5:0] t, logic [2:0] c, int unsigned len,
                                  int unsigned end_at, int unsigned idx, bit fe,
                                  int unsigned lead, logic [31:0] ts);
    out_t r;
    r.nal_type       = t;
    r.nal_class      = c;
    r.nal_length     = len[23:0];
    r.nal_end_offset = end_at[23:0];
    r.nal_index      = idx[7:0];
    r.frame_end      = fe;
    r.frame_length   = end_at[23:0];
    r.lead_bytes     = lead[23:0];
    r.time_stamp     = ts;
    return r;
  endfunction

  function automatic row_t plain(logic [7:0] d, bit last);
    return '{data: d, last: last, typed: 1'b0, has_rec: 1'b0, rec: '0};
  endfunction

  function automatic row_t quiet(logic [7:0] d);
    return '{data: d, last: 1'b0, typed: 1'b1, has_rec: 1'b0, rec: '0};
  endfunction

  function automatic row_t with_rec(logic [7:0] d, out_t r);
    return '{data: d, last: 1'b0, typed: 1'b1, has_rec: 1'b1, rec: r};
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  row_t plan [PLAN_ROWS];
  int   i;
  int   ph;
  logic phase_mode [8] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

  initial begin
    // Reset values of the registers, as the block comes out of reset
    mode_q = MODE_H264;
    step_q = TS_STEP_RESET;
    stamp  = '0;
    drop_stream();

    // H.264 rules, step 3600. Two lead bytes, then SPS (ended by a long code),
    // PPS, an IDR that closes the frame, a header-only P slice, a NAL with no
    // payload, and a buffer end that throws the open NAL away.
    plan = '{
      quiet(8'hFF), plain(8'hAB, 1'b0),
      plain(8'h00, 1'b0), plain(8'h00, 1'b0), plain(8'h01, 1'b0),
      plain(8'h67, 1'b0), plain(8'hAA, 1'b0),
      plain(8'h00, 1'b0), plain(8'h00, 1'b0), plain(8'h00, 1'b0),
      with_rec(8'h01, rec_of(AVC_SPS, CLS_SPS, 5, 5, 0, 1'b0, 2, 0)),
      plain(8'h68, 1'b0), plain(8'h00, 1'b0), plain(8'h00, 1'b0),
      with_rec(8'h01, rec_of(AVC_PPS, CLS_PPS, 5, 10, 1, 1'b0, 2, 0)),
      plain(8'h65, 1'b0), plain(8'h88, 1'b0), plain(8'h00, 1'b0), plain(8'h00, 1'b0),
      with_rec(8'h01, rec_of(AVC_IDR, CLS_I, 5, 15, 2, 1'b1, 2, 3600)),
      plain(8'h41, 1'b0), plain(8'h00, 1'b0), plain(8'h00, 1'b0),
      with_rec(8'h01, rec_of(AVC_SLICE, CLS_P, 4, 4, 0, 1'b1, 0, 7200)),
      plain(8'h00, 1'b0), plain(8'h00, 1'b0),
      with_rec(8'h01, rec_of(6'd0, CLS_OTHER, 3, 3, 0, 1'b0, 0, 7200)),
      plain(8'hFF, 1'b1)
    };

    // Hold reset, then release it on a rising edge
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < PLAN_ROWS; i++) begin
      typed_due.push_back(plan[i]);
      send_byte(plan[i].data, plan[i].last);
    end

    // Random phases. A phase may stop with a NAL still open, so a mode change
    // at the boundary lands between its header byte and its record.
    for (ph = 0; ph < 8; ph++) begin
      settle();
      write_reg(REG_CODEC_MODE, {15'd0, phase_mode[ph]});
      case (ph)
        0, 3:    write_reg(REG_TS_STEP, 16'd0);
        1, 2:    write_reg(REG_TS_STEP, 16'hFFFF);
        6:       write_reg(REG_TS_STEP, 16'd1);
        default: write_reg(REG_TS_STEP, 16'($urandom_range(0, 65535)));
      endcase
      // Some phases run back to back with no input gaps
      idle_gaps = (ph != 2 && ph != 5);
      if (ph == 4) feed_param_run();
      feed_random(135);
    end

    // Drain, then a short tail to catch stray records
    settle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
